[src/rmq_pkg.sv]
`timescale 1ns / 1ps

package rmq_pkg;

    // Widths of the entry and result fields
    localparam int ENTRY_W = 16;
    localparam int QW_W    = 15;
    localparam int QXYZ_W  = 16;

    // Number of quaternion components worked in parallel
    localparam int LANES   = 4;
    localparam int LANE_W  = 0;
    localparam int LANE_X  = 1;
    localparam int LANE_Y  = 2;
    localparam int LANE_Z  = 3;

    // Incoming word: the nine rotation entries
    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
    } in_t;

    // Outgoing word: the quaternion
    typedef struct packed {
        logic        [QW_W-1:0]   quat_w;
        logic signed [QXYZ_W-1:0] quat_x;
        logic signed [QXYZ_W-1:0] quat_y;
        logic signed [QXYZ_W-1:0] quat_z;
    } out_t;

endpackage

[src/rotation_matrix_to_quaternion.sv]
`timescale 1ns / 1ps

// Rotation matrix to quaternion. Takes one word of nine Q(FRAC_BITS) rotation
// entries per clock and returns w, x, y, z, each rounded to nearest and
// saturated at 1.0; x, y and z take the sign of their off-diagonal difference
// (positive when it is zero). Throughput is one matrix per clock while the
// output is not held. Stage 0 registers the diagonal sums and signs, the
// square root settles one result bit per pipeline stage over ROOT_W stages,
// and rounding, saturation and the sign go into the output register.
// A stall at the output freezes the whole pipeline in place;
// bubbles travel as cleared valid bits.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 14
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  rmq_pkg::in_t    item,
    output logic            result_valid,
    input  logic            result_ready,
    output rmq_pkg::out_t   result
);

    // Sum width covers one plus three entries; radicand is sum << FRAC_BITS
    localparam int SUM_W   = ((FRAC_BITS > rmq_pkg::ENTRY_W) ? FRAC_BITS : rmq_pkg::ENTRY_W) + 3;
    localparam int ROOT_W  = (SUM_W - 1 + FRAC_BITS + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int NST     = ROOT_W + 1;
    localparam int MAG_MAX = (FRAC_BITS >= rmq_pkg::QW_W) ? 32767 : (1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) << FRAC_BITS;
    localparam logic [ROOT_W-1:0] MAG_MAX_R = ROOT_W'(MAG_MAX);

    // Pipeline storage, stage 0 holds the sums, stage ROOT_W the finished roots
    logic                      vld_reg  [NST];
    logic [RAD_W-1:0]          rad_reg  [NST][rmq_pkg::LANES];
    logic [REM_W-1:0]          rem_reg  [NST][rmq_pkg::LANES];
    logic [ROOT_W-1:0]         root_reg [NST][rmq_pkg::LANES];
    logic [2:0]                neg_reg  [NST];

    logic                      vld_next [NST];
    logic [RAD_W-1:0]          rad_next [NST][rmq_pkg::LANES];
    logic [REM_W-1:0]          rem_next [NST][rmq_pkg::LANES];
    logic [ROOT_W-1:0]         root_next[NST][rmq_pkg::LANES];
    logic [2:0]                neg_next [NST];

    logic                      out_vld_reg;
    logic                      out_vld_next;
    rmq_pkg::out_t             out_reg;
    rmq_pkg::out_t             out_next;

    logic                      adv;
    logic signed [SUM_W-1:0]   e00, e11, e22;
    logic signed [SUM_W-1:0]   sum [rmq_pkg::LANES];
    logic [REM_W-1:0]          rem_sh [ROOT_W][rmq_pkg::LANES];
    logic [REM_W-1:0]          trial  [ROOT_W][rmq_pkg::LANES];
    logic                      ge     [ROOT_W][rmq_pkg::LANES];
    logic [ROOT_W:0]           rnd    [rmq_pkg::LANES];
    logic [ROOT_W-1:0]         mag    [rmq_pkg::LANES];
    logic [rmq_pkg::QW_W-1:0]  mag15  [rmq_pkg::LANES];
    logic [rmq_pkg::QXYZ_W-1:0] pos   [rmq_pkg::LANES];

    // Whole pipeline moves together unless the output word is held
    assign adv        = !out_vld_reg || result_ready;
    assign item_ready = adv;

    // Form the diagonal sums and the off-diagonal signs
    always_comb
    begin
        e00 = SUM_W'(item.m00);
        e11 = SUM_W'(item.m11);
        e22 = SUM_W'(item.m22);
        sum[rmq_pkg::LANE_W] = ONE_S + e00 + e11 + e22;
        sum[rmq_pkg::LANE_X] = ONE_S + e00 - e11 - e22;
        sum[rmq_pkg::LANE_Y] = ONE_S - e00 + e11 - e22;
        sum[rmq_pkg::LANE_Z] = ONE_S - e00 - e11 + e22;
        vld_next[0] = item_valid;
        neg_next[0] = {item.m10 < item.m01, item.m02 < item.m20, item.m21 < item.m12};
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            // Clamp non-positive sums to zero
            if (sum[l] <= 0)
                rad_next[0][l] = '0;
            else
                rad_next[0][l] = RAD_W'(sum[l][SUM_W-2:0]) << FRAC_BITS;
            rem_next[0][l]  = '0;
            root_next[0][l] = '0;
        end

        // Settle one root bit per stage
        for (int k = 0; k < ROOT_W; k++)
        begin
            vld_next[k+1] = vld_reg[k];
            neg_next[k+1] = neg_reg[k];
            for (int l = 0; l < rmq_pkg::LANES; l++)
            begin
                rem_sh[k][l] = {rem_reg[k][l][REM_W-3:0], rad_reg[k][l][RAD_W-1:RAD_W-2]};
                trial[k][l]  = {root_reg[k][l], 2'b01};
                ge[k][l]     = rem_sh[k][l] >= trial[k][l];
                rem_next[k+1][l]  = ge[k][l] ? (rem_sh[k][l] - trial[k][l]) : rem_sh[k][l];
                root_next[k+1][l] = {root_reg[k][l][ROOT_W-2:0], ge[k][l]};
                rad_next[k+1][l]  = rad_reg[k][l] << 2;
            end
        end
    end

    // Round, saturate and apply the signs
    always_comb
    begin
        for (int l = 0; l < rmq_pkg::LANES; l++)
        begin
            rnd[l]   = {1'b0, root_reg[ROOT_W][l]} + (ROOT_W + 1)'(1);
            mag[l]   = rnd[l][ROOT_W:1];
            if (mag[l] > MAG_MAX_R)
                mag[l] = MAG_MAX_R;
            mag15[l] = rmq_pkg::QW_W'(mag[l]);
            pos[l]   = {1'b0, mag15[l]};
        end
        out_vld_next   = vld_reg[ROOT_W];
        out_next.quat_w = mag15[rmq_pkg::LANE_W];
        out_next.quat_x = neg_reg[ROOT_W][0] ? -pos[rmq_pkg::LANE_X] : pos[rmq_pkg::LANE_X];
        out_next.quat_y = neg_reg[ROOT_W][1] ? -pos[rmq_pkg::LANE_Y] : pos[rmq_pkg::LANE_Y];
        out_next.quat_z = neg_reg[ROOT_W][2] ? -pos[rmq_pkg::LANE_Z] : pos[rmq_pkg::LANE_Z];
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            for (int k = 0; k < NST; k++)
                vld_reg[k] <= vld_next[k];
            out_vld_reg <= out_vld_next;
        end
    end

    // Advance the payload, hold it while stalled
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NST; k++)
            begin
                neg_reg[k] <= neg_next[k];
                for (int l = 0; l < rmq_pkg::LANES; l++)
                begin
                    rad_reg[k][l]  <= rad_next[k][l];
                    rem_reg[k][l]  <= rem_next[k][l];
                    root_reg[k][l] <= root_next[k][l];
                end
            end
            out_reg <= out_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // Scalar part never beyond saturation limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(result.quat_w) <= MAG_MAX))
        else $error("quat_w beyond saturation limit");

    // The x and z vector parts stay within plus or minus the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (int'(result.quat_x) <= MAG_MAX && int'(result.quat_x) >= -MAG_MAX
                       && int'(result.quat_z) <= MAG_MAX && int'(result.quat_z) >= -MAG_MAX))
        else $error("quat_x or quat_z beyond saturation limit");

    // A stall freezes the valid bits of the first and the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (vld_reg[0] == $past(vld_reg[0]) && vld_reg[ROOT_W] == $past(vld_reg[ROOT_W])))
        else $error("pipeline moved during stall");
`endif

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC_BITS    = 14;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 40;

    logic          clk;
    logic          rst_n;
    logic          item_valid;
    logic          item_ready;
    rmq_pkg::in_t  item;
    logic          result_valid;
    logic          result_ready;
    rmq_pkg::out_t result;

    // Set during stretches where neither side inserts gaps
    bit    no_idle;
    int    directed_sent;
    int    random_sent;

    rotation_matrix_to_quaternion #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Quaternion predictor and queue of quaternions still owed by the block
    class quat_scoreboard;
        rmq_pkg::out_t quat_q[$];
        int   checked    = 0;
        int   mismatches = 0;
        int   neg_parts  = 0;
        int   zero_w     = 0;

        static function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned root;
            longint unsigned bitpos;
            root   = 0;
            bitpos = 64'd1 << 62;
            while (bitpos > v)
                bitpos = bitpos >> 2;
            while (bitpos != 0)
            begin
                if (v >= root + bitpos)
                begin
                    v    = v - (root + bitpos);
                    root = (root >> 1) + bitpos;
                end
                else
                begin
                    root = root >> 1;
                end
                bitpos = bitpos >> 2;
            end
            return root;
        endfunction

        // Half the square root of a clamped diagonal sum, rounded and saturated
        static function logic [15:0] half_root(int diag_sum);
            longint unsigned root;
            longint unsigned mag;
            if (diag_sum <= 0)
                return 16'd0;
            root = int_sqrt(longint'(diag_sum) << FRAC_BITS);
            mag  = (root + 1) >> 1;
            if (mag > (64'd1 << FRAC_BITS))
                mag = 64'd1 << FRAC_BITS;
            if (mag > 64'd32767)
                mag = 64'd32767;
            return mag[15:0];
        endfunction

        // Apply the sign of the off-diagonal difference; zero counts as positive
        static function logic signed [15:0] signed_part(logic [15:0] mag, int diff);
            if (diff < 0)
                return -$signed(mag);
            return $signed(mag);
        endfunction

        static function rmq_pkg::out_t quat_of(rmq_pkg::in_t m);
            int   one;
            int   d00;
            int   d11;
            int   d22;
            rmq_pkg::out_t q;
            logic [15:0] mag_w;
            one   = 1 << FRAC_BITS;
            d00   = int'(m.m00);
            d11   = int'(m.m11);
            d22   = int'(m.m22);
            mag_w = half_root(one + d00 + d11 + d22);
            q.quat_w = mag_w[rmq_pkg::QW_W-1:0];
            q.quat_x = signed_part(half_root(one + d00 - d11 - d22),
                                   int'(m.m21) - int'(m.m12));
            q.quat_y = signed_part(half_root(one - d00 + d11 - d22),
                                   int'(m.m02) - int'(m.m20));
            q.quat_z = signed_part(half_root(one - d00 - d11 + d22),
                                   int'(m.m10) - int'(m.m01));
            return q;
        endfunction

        function void note_input(rmq_pkg::in_t m);
            quat_q.push_back(quat_of(m));
        endfunction

        function void check_result(rmq_pkg::out_t got);
            rmq_pkg::out_t want;
            checked++;
            if (got.quat_x < 0 || got.quat_y < 0 || got.quat_z < 0)
                neg_parts++;
            if (got.quat_w == '0)
                zero_w++;
            if (quat_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: quaternion with none owed: w=%0d x=%0d y=%0d z=%0d",
                             $time, got.quat_w, got.quat_x, got.quat_y, got.quat_z);
                return;
            end
            want = quat_q.pop_front();
            if (got.quat_w !== want.quat_w || got.quat_x !== want.quat_x ||
                got.quat_y !== want.quat_y || got.quat_z !== want.quat_z)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: quaternion %0d: expected w=%0d x=%0d y=%0d z=%0d,",
                              " got w=%0d x=%0d y=%0d z=%0d"},
                             $time, checked, want.quat_w, want.quat_x, want.quat_y,
                             want.quat_z, got.quat_w, got.quat_x, got.quat_y, got.quat_z);
            end
        endfunction

        function int pending();
            return quat_q.size();
        endfunction
    endclass

    quat_scoreboard sb;

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic rmq_pkg::in_t make_matrix(int a00, int a01, int a02,
                                                 int a10, int a11, int a12,
                                                 int a20, int a21, int a22);
        rmq_pkg::in_t m;
        m.m00 = 16'(a00);
        m.m01 = 16'(a01);
        m.m02 = 16'(a02);
        m.m10 = 16'(a10);
        m.m11 = 16'(a11);
        m.m12 = 16'(a12);
        m.m20 = 16'(a20);
        m.m21 = 16'(a21);
        m.m22 = 16'(a22);
        return m;
    endfunction

    function automatic int to_fixed(real v);
        return $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
    endfunction

    function automatic int entry_in_range();
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    // Proper rotation built from a random quaternion
    function automatic rmq_pkg::in_t random_rotation();
        real qw;
        real qx;
        real qy;
        real qz;
        real norm;
        qw   = real'(int'($urandom_range(0, 2000)) - 1000);
        qx   = real'(int'($urandom_range(0, 2000)) - 1000);
        qy   = real'(int'($urandom_range(0, 2000)) - 1000);
        qz   = real'(int'($urandom_range(0, 2000)) - 1000);
        norm = $sqrt(qw * qw + qx * qx + qy * qy + qz * qz);
        if (norm < 1.0)
            return make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        qw = qw / norm;
        qx = qx / norm;
        qy = qy / norm;
        qz = qz / norm;
        return make_matrix(
            to_fixed(1.0 - 2.0 * (qy * qy + qz * qz)),
            to_fixed(2.0 * (qx * qy - qz * qw)),
            to_fixed(2.0 * (qx * qz + qy * qw)),
            to_fixed(2.0 * (qx * qy + qz * qw)),
            to_fixed(1.0 - 2.0 * (qx * qx + qz * qz)),
            to_fixed(2.0 * (qy * qz - qx * qw)),
            to_fixed(2.0 * (qx * qz - qy * qw)),
            to_fixed(2.0 * (qy * qz + qx * qw)),
            to_fixed(1.0 - 2.0 * (qx * qx + qy * qy)));
    endfunction

    function automatic rmq_pkg::in_t random_matrix();
        int   r;
        int   e01;
        int   e02;
        int   e12;
        rmq_pkg::in_t m;
        r = $urandom_range(0, 99);
        if (r < 70)
            return random_rotation();
        if (r < 85)
            return make_matrix(entry_in_range(), entry_in_range(), entry_in_range(),
                               entry_in_range(), entry_in_range(), entry_in_range(),
                               entry_in_range(), entry_in_range(), entry_in_range());
        if (r < 95)
        begin
            m = rmq_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
            return m;
        end
        // Symmetric off-diagonal: every difference is zero
        e01 = entry_in_range();
        e02 = entry_in_range();
        e12 = entry_in_range();
        return make_matrix(entry_in_range(), e01, e02,
                           e01, entry_in_range(), e12,
                           e02, e12, entry_in_range());
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(rmq_pkg::in_t m);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= m;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_input(m);
    endtask

    task automatic send_directed(rmq_pkg::in_t m);
        send_word(m);
        directed_sent++;
    endtask

    // Stimulus
    initial
    begin
        sb            = new;
        no_idle       = 1'b0;
        directed_sent = 0;
        random_sent   = 0;
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        item          = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity and half turns about each axis
        send_directed(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        send_directed(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        send_directed(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        send_directed(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        // Quarter turns both ways about each axis
        send_directed(make_matrix(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        send_directed(make_matrix(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
        send_directed(make_matrix(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        send_directed(make_matrix(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        send_directed(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        send_directed(make_matrix(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        // Field extremes and saturation
        send_directed(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_directed(make_matrix(16384, 16384, 16384, 16384, 16384, 16384,
                                  16384, 16384, 16384));
        send_directed(make_matrix(-16384, -16384, -16384, -16384, -16384, -16384,
                                  -16384, -16384, -16384));
        send_directed(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                                  32767, 32767, 32767));
        send_directed(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                                  -32768, -32768, -32768));
        send_directed(make_matrix(32767, 32767, -32768, -32768, 32767, 32767,
                                  32767, -32768, 32767));
        // Diagonal sums landing exactly on zero and just below it
        send_directed(make_matrix(-16384, 5, -5, 7, 0, 0, 3, -3, 0));
        send_directed(make_matrix(-16385, 0, 0, 0, 0, 0, 0, 0, 0));
        // Alternating bit patterns
        send_directed(make_matrix(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                  16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        // Equal off-diagonal pairs: every sign falls back to positive
        send_directed(make_matrix(16384, 9000, -9000, 9000, 16384, 12000,
                                  -9000, 12000, 16384));

        // Random matrices, with a few stretches of back-to-back traffic
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 150 && i < 250) || (i >= 450 && i < 500);
            send_word(random_matrix());
            random_sent++;
        end
        no_idle = 1'b0;
        item_valid <= 1'b0;

        // Drain, then allow time for anything stray to appear
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d directed and %0d random matrices, %0d quaternions checked",
                 directed_sent, random_sent, sb.checked);
        $display("tb_top: %0d with a negative part, %0d with zero scalar, %0d mismatches",
                 sb.neg_parts, sb.zero_w, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Output side: random back-pressure, released during the no-idle stretches
    initial
    begin
        int hold;
        result_ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                result_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            result_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Check every quaternion the block hands over
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result);
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

[rotation_matrix_to_quaternion.f]
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion.sv
tb/sv/tb_top.sv
